@@ rtl/core/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and the rotate helper of the SHA-256 hash unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int WordW  = 32;
  localparam int BlockBytes = 64;
  localparam int DigestWords = 8;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_EMIT
  } sha_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_byte;   // store input byte, advance fill and length
    logic load_work;   // copy hash state into working vars, start schedule
    logic do_round;    // run one compression round
    logic fold;        // add working vars into hash state
    logic pad_fill;    // write one padding byte at the fill pointer
    logic pad_mark;    // padding byte is the 0x80 marker
    logic pad_len;     // length bytes go in the last eight slots of this block
    logic pad_clear;   // reset hash state, fill and length
  } sha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } sha_stat_t;

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic word_t rotr(input word_t v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage

@@ rtl/core/sha256_if.sv @@
// ----------------------------------------------------------------------------
// sha256_in_if / sha256_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last_byte;
  modport source (output valid, data_byte, has_byte, last_byte, input ready);
  modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sha256_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/sha256_datapath.sv @@
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, rolling schedule, round logic, hash state and length counter.
// ----------------------------------------------------------------------------
module sha256_datapath import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  sha_cmd_t   cmd,
  input  logic [7:0] in_byte,
  input  logic [2:0] out_sel,
  output sha_stat_t  stat,
  output word_t      out_word
);

  word_t       buffer [BlockBytes/4];
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [5:0]  round;
  word_t       hash [8];
  word_t       work [8];
  word_t       sched [16];
  word_t       w_cur;

  logic [7:0] pad_val;
  word_t w_next, sg0, sg1, s1, ch, t1, s0, maj;

  // Padding byte: 0x80 marker, zeros, then the length in the last eight
  always_comb begin
    pad_val = 8'h00;
    if (cmd.pad_mark)
      pad_val = PadByte;
    else if (cmd.pad_len && fill >= LenPos)
      pad_val = message_bits[{~fill[2:0], 3'b000} +: 8];
  end

  // Next schedule word, one round ahead, and the round function
  always_comb begin
    sg0    = rotr(sched[2], 7) ^ rotr(sched[2], 18) ^ (sched[2] >> 3);
    sg1    = rotr(sched[15], 17) ^ rotr(sched[15], 19) ^ (sched[15] >> 10);
    w_next = (round < 6'd15) ? sched[1] : sched[1] + sg0 + sched[10] + sg1;
    s1     = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch     = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1     = work[7] + s1 + ch + RoundK[round] + w_cur;
    s0     = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj    = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  end

  // Buffer writes, big-endian bytes within each word
  always_ff @(posedge clk) begin
    if (cmd.take_byte) buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= in_byte;
    else if (cmd.pad_fill) buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= pad_val;
  end

  // Fill pointer, length and hash state
  always_ff @(posedge clk) begin
    if (rst || cmd.pad_clear) begin
      fill <= '0;
      message_bits <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= InitHash[i];
    end else begin
      if (cmd.take_byte) begin
        fill <= fill + 6'd1;
        message_bits <= message_bits + 64'd8;
      end else if (cmd.pad_fill) begin
        fill <= fill + 6'd1;
      end
      if (cmd.fold)
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + work[i];
    end
  end

  // Round counter and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      round <= '0;
      w_cur <= buffer[0];
      for (int i = 0; i < 8; i++) work[i] <= hash[i];
      for (int i = 0; i < 16; i++) sched[i] <= buffer[i];
    end else if (cmd.do_round) begin
      round <= round + 6'd1;
      w_cur <= w_next;
      for (int i = 0; i < 15; i++) sched[i] <= sched[i+1];
      sched[15] <= w_cur;
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + s0 + maj;
    end
  end

  assign stat.fill = fill;
  assign stat.round_last = (round == 6'd63);
  assign out_word = hash[out_sel];

endmodule

@@ rtl/core/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256_ctrl
// Holds no logic; the hash unit's controller is sha256_seq.
// ----------------------------------------------------------------------------

@@ rtl/core/sha256_seq.sv @@
// ----------------------------------------------------------------------------
// sha256_seq
// Controller for intake, block compression, padding and digest beats.
// ----------------------------------------------------------------------------
module sha256_seq import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_has,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_sel,
  output sha_cmd_t   cmd,
  input  sha_stat_t  stat
);

  sha_state_t state, state_next;
  logic       closing, closing_next;   // message ended, padding owed
  logic       padded, padded_next;     // 0x80 already written
  logic       lenin, lenin_next;       // length lies in the block being padded
  logic [2:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      closing <= 1'b0;
      padded <= 1'b0;
      lenin <= 1'b0;
      sel <= '0;
    end else begin
      state <= state_next;
      closing <= closing_next;
      padded <= padded_next;
      lenin <= lenin_next;
      sel <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    closing_next = closing;
    padded_next = padded;
    lenin_next = lenin;
    sel_next = sel;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = in_has;
          closing_next = in_last;
          padded_next = 1'b0;
          lenin_next = 1'b0;
          if (in_has && stat.fill == 6'd63) state_next = S_LOAD;
          else if (in_last) state_next = S_PAD;
        end
      end
      S_LOAD: begin
        cmd.load_work = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round = 1'b1;
        if (stat.round_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (lenin) begin
          sel_next = '0;
          state_next = S_EMIT;
        end else if (closing) begin
          // marker already went out: the next block carries only the length
          if (padded) lenin_next = 1'b1;
          state_next = S_PAD;
        end else state_next = S_IDLE;
      end
      S_PAD: begin
        // one padding byte a cycle up to the block end
        cmd.pad_fill = 1'b1;
        padded_next = 1'b1;
        if (!padded) begin
          // marker first; the length fits only if the marker lands before byte 56
          cmd.pad_mark = 1'b1;
          lenin_next = (stat.fill < LenPos);
        end else begin
          cmd.pad_len = lenin;
        end
        if (stat.fill == 6'd63) state_next = S_LOAD;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          sel_next = sel + 3'd1;
          if (sel == 3'd7) begin
            cmd.pad_clear = 1'b1;
            closing_next = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_sel = sel;

endmodule

@@ rtl/core/sha256_message_hash_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hash_unit
// SHA-256 over a byte stream; eight digest words per closed message.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while a block fills. The 64th byte of a block
// starts compression: a load, the 64 rounds on one shared round unit and
// a fold, during which input is held off. A closing item writes the padding
// one byte a cycle to the block end (again into a second length block when
// the length does not fit), compresses, then presents the digest as eight
// beats, word 0 first; the unit returns to its initial hash afterwards.
module sha256_message_hash_unit import sha256_pkg::*; (
  input logic clk,
  input logic rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [2:0] sel;
  word_t      word;

  sha256_datapath u_dp (
    .clk, .rst, .cmd, .in_byte(in_ch.data_byte), .out_sel(sel), .stat,
    .out_word(word)
  );

  sha256_seq u_seq (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_has(in_ch.has_byte), .in_last(in_ch.last_byte),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_sel(sel),
    .cmd, .stat
  );

  assign out_ch.digest_word = word;
  assign out_ch.word_index = sel;
  assign out_ch.last_word = (sel == 3'd7);

endmodule

@@ rtl/core/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hash unit, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word,
  input logic [31:0] digest_word
);

  // never take a byte while a digest beat is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input open during digest");

  // digest words advance by one per taken beat
  a_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid &&
    word_index == $past(word_index) + 3'd1) else $error("word order broken");

  // after the last word the unit takes input again
  a_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("no return after digest");

  // a stalled beat holds its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest_word))
    else $error("digest word changed under stall");

endmodule

bind sha256_message_hash_unit sha256_checker u_chk (
  .clk, .rst, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .word_index(out_ch.word_index),
  .last_word(out_ch.last_word), .digest_word(out_ch.digest_word)
);

@@ verif/sha256_message_hash_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hash_unit_tb
// Streams byte messages into the hash unit and checks every digest beat
// against an in-bench SHA-256 predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sha256_message_hash_unit_tb import sha256_pkg::*; ();

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   hold_off = 0;

  sha256_in_if  in_ch (clk);
  sha256_out_if out_ch (clk);

  sha256_message_hash_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [31:0] hash_h [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] x, y, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x = w[(t + 1) & 15];
        y = w[(t + 14) & 15];
        w[t & 15] = w[t & 15] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[(t + 9) & 15]
                    + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t & 15];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) hash_h[i] = InitHash[i];
    fill = '0;
    msg_bits = '0;
  endtask

  // Advance the predictor by one accepted beat
  task automatic predict_digest(logic [7:0] b, logic has, logic last);
    digest_beat_t e;
    if (has) begin
      blk[fill] = b;
      fill = fill + 6'd1;
      msg_bits = msg_bits + 64'd8;
      if (fill == 6'd0) compress_blk();
    end
    if (last) begin
      blk[fill] = PadByte;
      for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
      if (fill >= LenPos) begin
        compress_blk();
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[63 - i] = msg_bits[8*i +: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        e.digest_word = hash_h[i];
        e.word_index  = i[2:0];
        e.last_word   = (i == 7);
        digest_q.push_back(e);
      end
      clear_hash();
    end
  endtask

  // Drive one beat and wait for acceptance; valid drops only across a gap
  task automatic send_beat(logic [7:0] b, logic has, logic last, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte  <= has;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_digest(b, has, last);
  endtask

  task automatic send_message(int n, bit no_gap = 1'b0);
    for (int i = 0; i < n; i++)
      send_beat(8'($urandom_range(0, 255)), 1'b1, i == n - 1, no_gap);
    if (n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, no_gap);
  endtask

  // Directed: empty message, idle beats, byte extremes, "abc"
  task automatic test_basic();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
  endtask

  // Directed: fill lengths around the length field and the block edge
  task automatic test_pad_edges();
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    for (int i = 0; i < 64; i++) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  // Receiver holds off long while the sender streams: the digest waits and input stalls
  task automatic test_backpressure();
    hold_off = 400;
    send_message(20, 1'b1);
    send_message(3, 1'b1);
  endtask

  // Random messages, mostly short, some multi-block, sprinkled idle beats
  task automatic test_random();
    int sent, n;
    sent = 0;
    while (sent < 120) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 140) : $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      sent += n + 1;
    end
  endtask

  // Receiver: random stall after each taken beat, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check each accepted digest beat against the oldest expectation
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected beat word %h idx %0d", $time, out_ch.digest_word,
                 out_ch.word_index);
        fail_count++;
      end else begin
        e = digest_q.pop_front();
        if (out_ch.digest_word !== e.digest_word) begin
          $display("%0t: digest_word exp %h got %h", $time, e.digest_word,
                   out_ch.digest_word);
          fail_count++;
        end
        if (out_ch.word_index !== e.word_index) begin
          $display("%0t: word_index exp %0d got %0d", $time, e.word_index,
                   out_ch.word_index);
          fail_count++;
        end
        if (out_ch.last_word !== e.last_word) begin
          $display("%0t: last_word exp %0b got %0b", $time, e.last_word, out_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.has_byte  <= 1'b0;
    in_ch.last_byte <= 1'b0;
    clear_hash();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_basic();
    test_pad_edges();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
